### rtl/wfr_pkg.sv
// ============================================================================
// wfr_pkg
// Shared types and constants of the Wiegand frame receiver.
// ============================================================================
package wfr_pkg;

   // Item kinds on the request channel.
   localparam logic [1:0] ACT_DATA0 = 2'd0;
   localparam logic [1:0] ACT_DATA1 = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   localparam int ACTION_W    = 2;
   localparam int LIMIT_W     = 6;
   localparam int BITCOUNT_W  = 9;
   localparam int BYTE_W      = 8;
   localparam int TIMER_W     = 24;
   localparam int RESULT_CAP  = 32;

   localparam logic [TIMER_W-1:0] TIMER_MAX     = '1;
   localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 24'd3000;

   // Register index as decoded from the word offset of the address.
   localparam logic REG_TIMEOUT = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PULSE_WR,
      ST_RD_DATA,
      ST_EMPTY
   } state_type;

endpackage

### rtl/wiegand_frame_receiver.sv
// ============================================================================
// wiegand_frame_receiver
// Wiegand card-reader frame receiver with a byte store and idle timer.
// ============================================================================
// D0/D1 pulse words shift one bit into the current byte of the frame store.
// A pulse that stores its bit reads the byte from the store memory and
// writes it back in the next cycle, during which the request side holds
// off. A pulse that finds the store full drops its bit. The first result
// word of a read word passes through the store read register and then the
// output register. For a completed frame the store is then read one byte
// a cycle while rsp_tready stays high, so its results leave at one word
// per cycle, and the request side holds off until the last of them is
// loaded. Otherwise one empty word is returned while the request side
// holds off. Each store entry has a valid bit that reset and frame clearing
// drop at once, so there is no clearing pass after reset. The timeout
// register is written over the CSR port; the user must write it only while
// the block is idle, as the block itself does not enforce this.
module wiegand_frame_receiver #(
   parameter int MAX_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] read_limit, [7:6] zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [8:0] bit_count, [16:9] data_byte, [23:17] zero
   output logic        rsp_tuser,   // [0] byte_valid
   output logic        rsp_tlast,   // last
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int CNT_W  = $clog2(MAX_BYTES * 8 + 1);
   localparam int SLOT_W = CNT_W - 3;
   localparam int CAP    = (MAX_BYTES < wfr_pkg::RESULT_CAP) ? MAX_BYTES
                                                             : wfr_pkg::RESULT_CAP;
   localparam int CW     = ((SLOT_W > wfr_pkg::LIMIT_W) ? SLOT_W : wfr_pkg::LIMIT_W) + 1;
   localparam int LW     = wfr_pkg::LIMIT_W;
   localparam int BW     = wfr_pkg::BYTE_W;
   localparam int TW     = wfr_pkg::TIMER_W;

   // Frame store.
   logic [BW-1:0]        mem [MAX_BYTES];
   logic                 mem_re;
   logic [IDX_W-1:0]     mem_raddr;
   logic                 mem_we;
   logic [BW-1:0]        mem_wdata;
   logic [BW-1:0]        rd_data_ff;
   logic                 rd_vld_ff;
   logic [BW-1:0]        rd_byte;

   wfr_pkg::state_type   state_ff, state_in;
   logic [MAX_BYTES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]     bits_ff, bits_in;
   logic [TW-1:0]        idle_ff, idle_in;
   logic [TW-1:0]        timeout_ff;
   logic [IDX_W-1:0]     slot_idx_ff, slot_idx_in;
   logic                 bit_ff, bit_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [LW-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [wfr_pkg::BITCOUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [BW-1:0]        rsp_byte_ff, rsp_byte_in;
   logic                 rsp_bvalid_ff, rsp_bvalid_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_accept;
   logic                 out_free;
   logic [SLOT_W-1:0]    slot;
   logic                 complete;
   logic [CW-1:0]        slot_x, lim_x, lim_c, n_x;
   logic [LW-1:0]        n_bytes;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == wfr_pkg::REG_TIMEOUT) ? {8'd0, timeout_ff} : 32'd0;

   assign req_tready = (state_ff == wfr_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_byte_ff, rsp_cnt_ff};
   assign rsp_tuser  = rsp_bvalid_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign slot     = bits_ff[CNT_W-1:3];
   assign complete = (bits_ff != '0) && (idle_ff > timeout_ff);
   assign rd_byte  = rd_vld_ff ? rd_data_ff : '0;

   // Bytes to send: through the slot bits_ff points at, capped by limit and store.
   always_comb begin
      slot_x  = CW'(slot);
      lim_x   = CW'(req_tdata[LW-1:0]);
      lim_c   = (lim_x > CW'(CAP)) ? CW'(CAP) : lim_x;
      n_x     = (slot_x >= lim_c) ? lim_c : slot_x + CW'(1);
      n_bytes = n_x[LW-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      bits_in       = bits_ff;
      idle_in       = idle_ff;
      slot_idx_in   = slot_idx_ff;
      bit_in        = bit_ff;
      rd_idx_in     = rd_idx_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      mem_we        = 1'b0;
      mem_wdata     = {rd_byte[BW-2:0], bit_ff};

      case (state_ff)
         wfr_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_tuser)
                  wfr_pkg::ACT_DATA0, wfr_pkg::ACT_DATA1: begin
                     idle_in = '0;
                     // A full store drops the bit but still restarts the timer.
                     if (slot < SLOT_W'(MAX_BYTES)) begin
                        mem_re      = 1'b1;
                        mem_raddr   = slot[IDX_W-1:0];
                        slot_idx_in = slot[IDX_W-1:0];
                        bit_in      = req_tuser[0];
                        state_in    = wfr_pkg::ST_PULSE_WR;
                     end
                  end
                  wfr_pkg::ACT_TICK: begin
                     if (idle_ff != wfr_pkg::TIMER_MAX) begin
                        idle_in = idle_ff + TW'(1);
                     end
                  end
                  default: begin
                     cnt_in = complete ? bits_ff : '0;
                     if (complete && (n_bytes != '0)) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        rd_idx_in = IDX_W'(1);
                        rem_in    = n_bytes;
                        state_in  = wfr_pkg::ST_RD_DATA;
                     end else begin
                        if (complete) begin
                           bits_in  = '0;
                           valid_in = '0;
                        end
                        state_in = wfr_pkg::ST_EMPTY;
                     end
                  end
               endcase
            end
         end
         wfr_pkg::ST_PULSE_WR: begin
            mem_we                = 1'b1;
            valid_in[slot_idx_ff] = 1'b1;
            bits_in               = bits_ff + CNT_W'(1);
            state_in              = wfr_pkg::ST_IDLE;
         end
         wfr_pkg::ST_RD_DATA: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cnt_in    = wfr_pkg::BITCOUNT_W'(cnt_ff);
               rsp_byte_in   = rd_byte;
               rsp_bvalid_in = 1'b1;
               rsp_last_in   = (rem_ff == LW'(1));
               if (rem_ff == LW'(1)) begin
                  bits_in  = '0;
                  valid_in = '0;
                  state_in = wfr_pkg::ST_IDLE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = rd_idx_ff;
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
                  rem_in    = rem_ff - LW'(1);
               end
            end
         end
         wfr_pkg::ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cnt_in    = wfr_pkg::BITCOUNT_W'(cnt_ff);
               rsp_byte_in   = '0;
               rsp_bvalid_in = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = wfr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wfr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wfr_pkg::ST_IDLE;
         valid_ff     <= '0;
         bits_ff      <= '0;
         idle_ff      <= wfr_pkg::TIMER_MAX;
         timeout_ff   <= wfr_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         bits_ff      <= bits_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr && (csr_paddr[2] == wfr_pkg::REG_TIMEOUT)) begin
            timeout_ff <= csr_pwdata[TW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_idx_ff   <= slot_idx_in;
      bit_ff        <= bit_in;
      rd_idx_ff     <= rd_idx_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Store memory: one read and one write port, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[slot_idx_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
         rd_vld_ff  <= valid_ff[mem_raddr];
      end
   end

endmodule

### rtl/wfr_checker.sv
// ============================================================================
// wfr_checker
// Port-level checks of the Wiegand frame receiver result channel.
// ============================================================================
module wfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // A word without a frame byte always ends its read.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("empty result word not marked last");

   // Only byte-carrying words can be followed by more words of the same read.
   a_mid_has_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser && (rsp_tdata[8:0] != 9'd0))
      else $error("non-final result word without a byte or bit count");

   // Nothing is presented right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind wiegand_frame_receiver wfr_checker u_wfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
